[rtl/sync_link_state_with_backoff_defines.svh]
// Assertion macros for the link sequencer
`ifndef SYNC_LINK_STATE_WITH_BACKOFF_DEFINES_SVH
`define SYNC_LINK_STATE_WITH_BACKOFF_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SLB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

// antecedent implies consequent in the next cycle
`define SLB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

`else

`define SLB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define SLB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[rtl/slb_pkg.sv]
package slb_pkg;

   // link states
   typedef enum logic [2:0] {
      ST_DISABLED  = 3'd0,
      ST_HANDSHAKE = 3'd1,
      ST_AUTH      = 3'd2,
      ST_SYNCING   = 3'd3,
      ST_IDLE      = 3'd4,
      ST_BACKOFF   = 3'd5,
      ST_ERROR     = 3'd6
   } link_state_type;

   // event codes; 9..15 are invalid
   typedef enum logic [3:0] {
      EV_CONNECTED = 4'd0,
      EV_AUTH_OK   = 4'd1,
      EV_SYNC_DONE = 4'd2,
      EV_WORK      = 4'd3,
      EV_TRANSIENT = 4'd4,
      EV_FATAL     = 4'd5,
      EV_RETRY     = 4'd6,
      EV_ENABLE    = 4'd7,
      EV_DISABLE   = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_OFF     = 2'd1,
      STATUS_ILLEGAL = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   // csr register indexes
   localparam logic [1:0] CSR_BACKOFF_BASE = 2'd0;
   localparam logic [1:0] CSR_BACKOFF_MAX  = 2'd1;
   localparam logic [1:0] CSR_MAX_RETRY    = 2'd2;

   localparam logic [15:0] BACKOFF_BASE_RESET = 16'd500;
   localparam logic [31:0] BACKOFF_MAX_RESET  = 32'd60000;
   localparam logic [3:0]  MAX_RETRY_RESET    = 4'd8;

   // legal moves: row is the current state, bit is the target state
   localparam logic [7:0][7:0] LEGAL_MOVE = {
      8'h00, 8'h01, 8'h43, 8'h69, 8'h71, 8'h69, 8'h65, 8'h02
   };

   typedef struct packed {
      logic [3:0]  event_code;
      logic [63:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  state_now;
      logic        is_enabled;
      logic [3:0]  retry_count;
      logic [31:0] backoff_delay_ms;
      logic [63:0] resume_at_ms;
      logic        is_active;
   } rsp_word_type;

   // backoff unit result
   typedef struct packed {
      logic [3:0]  retry;
      logic [31:0] delay_ms;
      logic [63:0] deadline_ms;
   } backoff_type;

   // target state of a protocol event
   function automatic link_state_type target_of(input logic [3:0] ev);
      link_state_type to;
      unique case (ev)
         EV_CONNECTED: to = ST_AUTH;
         EV_AUTH_OK:   to = ST_SYNCING;
         EV_SYNC_DONE: to = ST_IDLE;
         EV_WORK:      to = ST_SYNCING;
         EV_TRANSIENT: to = ST_BACKOFF;
         EV_FATAL:     to = ST_ERROR;
         EV_RETRY:     to = ST_HANDSHAKE;
         default:      to = ST_DISABLED;
      endcase
      return to;
   endfunction

   function automatic logic legal_move(input logic [2:0] from, input logic [2:0] to);
      return LEGAL_MOVE[from][to];
   endfunction

endpackage

[rtl/slb_backoff_calc.sv]
module slb_backoff_calc (
   input  logic [3:0]          retry_cur,
   input  logic [3:0]          max_retry,
   input  logic [15:0]         base_ms,
   input  logic [31:0]         max_ms,
   input  logic [63:0]         now_ms,
   output slb_pkg::backoff_type result
);
   import slb_pkg::*;

   logic [3:0]  retry_next;
   logic [3:0]  shift_amt;
   logic [29:0] shifted;
   logic [31:0] clipped;

   // saturating bump; a count already above the limit stays put
   assign retry_next = (retry_cur < max_retry) ? retry_cur + 4'd1 : retry_cur;
   assign shift_amt  = (retry_next != 4'd0) ? retry_next - 4'd1 : 4'd0;

   // base << (retry - 1), at most 30 bits, clipped to the ceiling
   assign shifted = {14'd0, base_ms} << shift_amt;
   assign clipped = ({2'd0, shifted} > max_ms) ? max_ms : {2'd0, shifted};

   assign result.retry       = retry_next;
   assign result.delay_ms    = clipped;
   assign result.deadline_ms = now_ms + {32'd0, clipped};

endmodule

[rtl/sync_link_state_with_backoff.sv]
// Link sequencer with exponential backoff. One event word in gives one
// response word out; a new word is accepted every cycle while the output
// side keeps up. The request word is registered in the input stage, then
// the table check, the backoff shift, clip and 64-bit deadline add run in
// one pass into the response register, which also updates the sequencer
// state. The user must write backoff parameters through the csr port only
// while no event is in flight; the block itself does not enforce this.
module sync_link_state_with_backoff (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  slb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output slb_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import slb_pkg::*;

`include "sync_link_state_with_backoff_defines.svh"

   // configuration
   logic [15:0] base_ms_ff;
   logic [31:0] max_ms_ff;
   logic [3:0]  max_retry_ff;

   // input stage
   logic         in_valid_ff;
   req_word_type in_word_ff;

   // sequencer state
   logic           enabled_ff,  enabled_in;
   link_state_type link_ff,     link_in;
   status_type     last_err_ff, last_err_in;
   logic [3:0]     retry_ff,    retry_in;
   logic [63:0]    deadline_ff, deadline_in;

   // output stage
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic         advance;
   logic         process;
   status_type   status_in;
   logic [31:0]  delay_in;
   link_state_type to_state;
   backoff_type  bk;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   slb_backoff_calc u_backoff (
      .retry_cur (retry_ff),
      .max_retry (max_retry_ff),
      .base_ms   (base_ms_ff),
      .max_ms    (max_ms_ff),
      .now_ms    (in_word_ff.now_ms),
      .result    (bk)
   );

   assign to_state = target_of(in_word_ff.event_code);

   // event decode: enable and disable first, then the gate, then code validity, then the legality table
   always_comb begin
      enabled_in  = enabled_ff;
      link_in     = link_ff;
      retry_in    = retry_ff;
      deadline_in = deadline_ff;
      status_in   = STATUS_OK;
      delay_in    = 32'd0;
      priority if (in_word_ff.event_code == EV_ENABLE) begin
         enabled_in  = 1'b1;
         retry_in    = 4'd0;
         deadline_in = 64'd0;
         link_in     = ST_HANDSHAKE;
      end else if (in_word_ff.event_code == EV_DISABLE) begin
         enabled_in  = 1'b0;
         retry_in    = 4'd0;
         deadline_in = 64'd0;
         link_in     = ST_DISABLED;
      end else if (!enabled_ff) begin
         status_in = STATUS_OFF;
      end else if (in_word_ff.event_code > EV_RETRY) begin
         status_in = STATUS_INVALID;
      end else begin
         // backoff is armed even if the move is refused
         if (in_word_ff.event_code == EV_TRANSIENT) begin
            retry_in    = bk.retry;
            deadline_in = bk.deadline_ms;
            delay_in    = bk.delay_ms;
         end
         if (in_word_ff.event_code == EV_AUTH_OK || in_word_ff.event_code == EV_SYNC_DONE) begin
            retry_in = 4'd0;
         end
         if (legal_move(link_ff, to_state)) begin
            link_in = to_state;
         end else begin
            status_in = STATUS_ILLEGAL;
         end
      end
      // enable and disable always report ok, so this also clears the error
      last_err_in = status_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ms_ff   <= BACKOFF_BASE_RESET;
         max_ms_ff    <= BACKOFF_MAX_RESET;
         max_retry_ff <= MAX_RETRY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BACKOFF_BASE: base_ms_ff   <= csr_wdata[15:0];
            CSR_BACKOFF_MAX:  max_ms_ff    <= csr_wdata;
            CSR_MAX_RETRY:    max_retry_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   // state update and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         link_ff      <= ST_DISABLED;
         last_err_ff  <= STATUS_OK;
         retry_ff     <= 4'd0;
         deadline_ff  <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (process) begin
            enabled_ff  <= enabled_in;
            link_ff     <= link_in;
            last_err_ff <= last_err_in;
            retry_ff    <= retry_in;
            deadline_ff <= deadline_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_word_ff.status           <= status_in;
         rsp_word_ff.state_now        <= link_in;
         rsp_word_ff.is_enabled       <= enabled_in;
         rsp_word_ff.retry_count      <= retry_in;
         rsp_word_ff.backoff_delay_ms <= delay_in;
         rsp_word_ff.resume_at_ms     <= deadline_in;
         rsp_word_ff.is_active        <= enabled_in && (link_in >= ST_HANDSHAKE)
                                         && (link_in <= ST_IDLE);
      end
   end

   // the pending response always reflects the latest stored error
   `SLB_ASSERT_IMPLIES(a_last_err_matches, clock, reset, rsp_valid_ff, last_err_ff == rsp_word_ff.status)

   // no event ever targets disabled, so only the gate decides it
   `SLB_ASSERT_IMPLIES(a_disabled_iff_gate, clock, reset, 1'b1, (link_ff == ST_DISABLED) == !enabled_ff)

   // a stalled input word is held until it is processed
   `SLB_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff))

endmodule
